FILE: hw/rtl/mbi_pkg.sv
// ----------------------------------------------------------------------------
// mbi_pkg
// Shared types, codes and defaults of the Mandelbrot escape iterator.
// ----------------------------------------------------------------------------
package mbi_pkg;

    localparam int DEF_FRAC_BITS  = 52;
    localparam int DEF_INDEX_BITS = 12;
    localparam int DEF_COUNT_BITS = 16;

    localparam logic [15:0] DEF_ITER_LIMIT = 16'd1000;
    localparam logic [63:0] DEF_LEFT_REAL  = 64'hFFD8_0000_0000_0000;
    localparam logic [63:0] DEF_TOP_IMAG   = 64'hFFEE_0000_0000_0000;
    localparam logic [62:0] DEF_PIXEL_STEP = 63'd9382499223689;

    // configuration register indexes
    localparam logic [7:0] CFG_ITER_LIMIT = 8'd0;
    localparam logic [7:0] CFG_LEFT_REAL  = 8'd1;
    localparam logic [7:0] CFG_TOP_IMAG   = 8'd2;
    localparam logic [7:0] CFG_PIXEL_STEP = 8'd3;

    localparam logic [32:0] ONE_Q32 = 33'h1_0000_0000;

    typedef enum logic [2:0] {
        S_IDLE, S_ISSUE, S_WAIT, S_CHECK, S_TEST, S_UPDATE, S_FINISH
    } t_state;

    // products formed by the shared multiply-accumulate unit
    typedef enum logic [3:0] {
        OP_CR, OP_CI, OP_RR, OP_II, OP_P1, OP_P2, OP_Q1, OP_Q2, OP_X
    } t_op;

    typedef struct packed {
        logic start;
        logic keep;   // add onto the previous sum instead of clearing
        logic sub;    // subtract the product
    } t_mac_cmd;

endpackage

FILE: hw/rtl/mbi_mac.sv
// ----------------------------------------------------------------------------
// mbi_mac
// Signed 64x64 multiply-accumulate over four 33x33 partial products.
// ----------------------------------------------------------------------------
module mbi_mac import mbi_pkg::*; (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  t_mac_cmd     i_cmd,
    input  logic [63:0]  i_a,
    input  logic [63:0]  i_b,
    output logic         o_done,
    output logic [127:0] o_acc
);

    logic               r_busy;
    logic [2:0]         r_cnt;
    logic               r_keep;
    logic               r_sub;
    logic [63:0]        r_a;
    logic [63:0]        r_b;
    logic signed [65:0] r_prod;
    logic [1:0]         r_sh;
    logic [127:0]       r_acc;
    logic               r_done;

    logic [1:0]         part;
    logic signed [32:0] opa;
    logic signed [32:0] opb;
    logic signed [65:0] mp;
    logic [127:0]       ext;
    logic [127:0]       term;
    logic [127:0]       base;
    logic [127:0]       n_acc;

    always_comb begin
        part = r_cnt[1:0];
        opa  = part[1] ? {r_a[63], r_a[63:32]} : {1'b0, r_a[31:0]};
        opb  = part[0] ? {r_b[63], r_b[63:32]} : {1'b0, r_b[31:0]};
        mp   = opa * opb;
        ext  = {{62{r_prod[65]}}, r_prod};
        case (r_sh)
            2'd0:    term = ext;
            2'd1:    term = ext << 32;
            default: term = ext << 64;
        endcase
        base  = (r_cnt == 3'd1 && !r_keep) ? 128'd0 : r_acc;
        n_acc = r_sub ? base - term : base + term;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= 3'd0;
        end else begin
            r_done <= !i_cmd.start && r_busy && (r_cnt == 3'd4);
            if (i_cmd.start) begin
                r_busy <= 1'b1;
                r_cnt  <= 3'd0;
                r_keep <= i_cmd.keep;
                r_sub  <= i_cmd.sub;
                r_a    <= i_a;
                r_b    <= i_b;
            end else if (r_busy) begin
                if (r_cnt != 3'd4) begin
                    r_prod <= mp;
                    r_sh   <= {part[1] & part[0], part[1] ^ part[0]};
                end
                if (r_cnt != 3'd0) begin
                    r_acc <= n_acc;
                end
                if (r_cnt == 3'd4) begin
                    r_busy <= 1'b0;
                end
                r_cnt <= r_cnt + 3'd1;
            end
        end
    end

    assign o_done = r_done;
    assign o_acc  = r_acc;

endmodule

FILE: hw/rtl/mandelbrot_escape_iterator.sv
// ----------------------------------------------------------------------------
// mandelbrot_escape_iterator
// Escape-time iteration with running derivative, signed fixed point.
// ----------------------------------------------------------------------------
// Each multiply-accumulate op runs on the single shared 33x33 multiplier,
// seven ops per step plus the check, test and update states. One item at a
// time: input ready again once the result is in the output register, which
// waits in finish while the output is still held.
// Reset (synchronous, active low) clears the sequencer and output valid and
// restores the register defaults.
// ----------------------------------------------------------------------------
module mandelbrot_escape_iterator import mbi_pkg::*; #(
    parameter int FRAC_BITS  = DEF_FRAC_BITS,
    parameter int INDEX_BITS = DEF_INDEX_BITS,
    parameter int COUNT_BITS = DEF_COUNT_BITS
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    // column [11:0], pixel_row [23:12]
    input  logic [23:0]  i_s_axis_tdata,
    input  logic         i_s_axis_tvalid,
    output logic         o_s_axis_tready,
    // iterations [15:0], final_radius_sq [69:16], orbit_min_sq [102:70],
    // deriv_real [166:103], deriv_imag [230:167], zero fill [231]
    output logic [231:0] o_m_axis_tdata,
    // inside_res [0], deriv_saturated [1]
    output logic [1:0]   o_m_axis_tuser,
    output logic         o_m_axis_tvalid,
    input  logic         i_m_axis_tready,
    input  logic         i_cfg_valid,
    output logic         o_cfg_ready,
    input  logic [7:0]   i_cfg_index,
    input  logic [63:0]  i_cfg_data
);

    localparam int           SQ_SHIFT = 2 * FRAC_BITS - 32;
    localparam logic [127:0] ONE_D    = 128'd1 << (FRAC_BITS + 32);
    localparam logic [127:0] LIMIT    = 128'd1000 << (2 * FRAC_BITS);
    localparam logic [15:0]  IDX_MASK = 16'((32'd1 << INDEX_BITS) - 32'd1);
    localparam logic [63:0]  POS_MAX  = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam logic [63:0]  SIGN64   = 64'h8000_0000_0000_0000;
    localparam logic [127:0] RAD_MAX  = (128'd1 << 54) - 128'd1;

    // origin + product with upward saturation; the product is never negative
    function automatic logic [63:0] coord_f(input logic [63:0] origin,
                                            input logic [127:0] prod);
        logic [64:0] s;
        s = {1'b0, origin ^ SIGN64} + {1'b0, prod[63:0]};
        if (prod[127:64] != 64'd0 || s[64]) return POS_MAX;
        return s[63:0] ^ SIGN64;
    endfunction

    // clamp to signed 64 bits, hit flag on top
    function automatic logic [64:0] clamp_f(input logic [127:0] x);
        if (x[127:63] == {65{1'b0}} || x[127:63] == {65{1'b1}})
            return {1'b0, x[63:0]};
        return {1'b1, x[127] ? SIGN64 : POS_MAX};
    endfunction

    t_state r_state, n_state;
    t_op    r_op;

    logic [COUNT_BITS-1:0] r_max;
    logic [63:0]           r_left;
    logic [63:0]           r_top;
    logic [62:0]           r_step;

    logic [15:0]           r_col, r_row;
    logic [63:0]           r_cr, r_ci, r_zr, r_zi, r_dr, r_di;
    logic [127:0]          r_rr, r_ii, r_p, r_q, r_x, r_sq;
    logic [COUNT_BITS-1:0] r_n;
    logic [32:0]           r_orbit;
    logic                  r_dsat;

    logic                  r_out_valid;
    logic [15:0]           r_o_iter;
    logic                  r_o_inside;
    logic [53:0]           r_o_radius;
    logic [32:0]           r_o_orbit;
    logic [63:0]           r_o_dr, r_o_di;
    logic                  r_o_dsat;

    t_mac_cmd              mac_cmd;
    logic [63:0]           mac_a, mac_b;
    logic                  mac_done;
    logic [127:0]          mac_acc;

    logic                  in_acc, out_free, brk;
    logic [127:0]          sq_q;
    logic [32:0]           orbit_v;
    logic [64:0]           nzr, nzi, ndr, ndi;
    logic [31:0]           n32;

    mbi_mac u_mac (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (mac_cmd),
        .i_a     (mac_a),
        .i_b     (mac_b),
        .o_done  (mac_done),
        .o_acc   (mac_acc)
    );

    // operand selection for the current product
    always_comb begin
        mac_a = r_zr;
        mac_b = r_zr;
        case (r_op)
            OP_CR:   begin mac_a = {48'd0, r_col}; mac_b = {1'b0, r_step}; end
            OP_CI:   begin mac_a = {48'd0, r_row}; mac_b = {1'b0, r_step}; end
            OP_RR:   begin mac_a = r_zr; mac_b = r_zr; end
            OP_II:   begin mac_a = r_zi; mac_b = r_zi; end
            OP_P1:   begin mac_a = r_zr; mac_b = r_dr; end
            OP_P2:   begin mac_a = r_zi; mac_b = r_di; end
            OP_Q1:   begin mac_a = r_zi; mac_b = r_dr; end
            OP_Q2:   begin mac_a = r_zr; mac_b = r_di; end
            OP_X:    begin mac_a = r_zr; mac_b = r_zi; end
            default: begin mac_a = r_zr; mac_b = r_zr; end
        endcase
    end

    // step arithmetic and tests; floor shifts stay arithmetic inside the sums
    always_comb begin
        in_acc   = i_s_axis_tvalid && o_s_axis_tready;
        out_free = !r_out_valid || i_m_axis_tready;
        brk      = (r_n >= r_max) || (r_sq >= LIMIT);
        sq_q     = r_sq >> SQ_SHIFT;
        orbit_v  = (sq_q > 128'(ONE_Q32)) ? ONE_Q32 : sq_q[32:0];
        nzr = clamp_f($signed($signed(r_rr - r_ii) >>> FRAC_BITS)
                      + {{64{r_cr[63]}}, r_cr});
        nzi = clamp_f($signed($signed(r_x << 1) >>> FRAC_BITS)
                      + {{64{r_ci[63]}}, r_ci});
        ndr = clamp_f($signed((r_p << 1) + ONE_D) >>> FRAC_BITS);
        ndi = clamp_f($signed(r_q << 1) >>> FRAC_BITS);
        n32 = 32'(r_n);
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:   if (in_acc) n_state = S_ISSUE;
            S_ISSUE:  n_state = S_WAIT;
            S_WAIT: begin
                if (mac_done) begin
                    case (r_op)
                        OP_II:   n_state = S_CHECK;
                        OP_X:    n_state = S_UPDATE;
                        default: n_state = S_ISSUE;
                    endcase
                end
            end
            S_CHECK:  n_state = S_TEST;
            S_TEST:   n_state = brk ? S_FINISH : S_ISSUE;
            S_UPDATE: n_state = S_ISSUE;
            S_FINISH: if (out_free) n_state = S_IDLE;
            default:  n_state = S_IDLE;
        endcase
    end

    // control outputs
    always_comb begin
        o_s_axis_tready = (r_state == S_IDLE);
        o_cfg_ready     = 1'b1;
        mac_cmd.start   = (r_state == S_ISSUE);
        mac_cmd.keep    = (r_op == OP_P2) || (r_op == OP_Q2);
        mac_cmd.sub     = (r_op == OP_P2);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_op        <= OP_CR;
            r_out_valid <= 1'b0;
            r_max       <= COUNT_BITS'(DEF_ITER_LIMIT);
            r_left      <= DEF_LEFT_REAL;
            r_top       <= DEF_TOP_IMAG;
            r_step      <= DEF_PIXEL_STEP;
            r_n         <= '0;
            r_orbit     <= ONE_Q32;
            r_dsat      <= 1'b0;
        end else begin
            r_state <= n_state;

            // configuration writes
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    CFG_ITER_LIMIT: r_max  <= COUNT_BITS'(i_cfg_data[15:0]);
                    CFG_LEFT_REAL:  r_left <= i_cfg_data;
                    CFG_TOP_IMAG:   r_top  <= i_cfg_data;
                    CFG_PIXEL_STEP: r_step <= i_cfg_data[62:0];
                    default: ;
                endcase
            end

            // capture the pixel and start with the coordinate products
            if (in_acc) begin
                r_col <= {4'd0, i_s_axis_tdata[11:0]} & IDX_MASK;
                r_row <= {4'd0, i_s_axis_tdata[23:12]} & IDX_MASK;
                r_op  <= OP_CR;
            end

            // store each finished product and advance the op
            if (r_state == S_WAIT && mac_done) begin
                case (r_op)
                    OP_CR: begin
                        r_cr <= coord_f(r_left, mac_acc);
                        r_op <= OP_CI;
                    end
                    OP_CI: begin
                        r_ci    <= coord_f(r_top, mac_acc);
                        r_zr    <= '0;
                        r_zi    <= '0;
                        r_dr    <= '0;
                        r_di    <= '0;
                        r_n     <= '0;
                        r_orbit <= ONE_Q32;
                        r_dsat  <= 1'b0;
                        r_op    <= OP_RR;
                    end
                    OP_RR: begin r_rr <= mac_acc; r_op <= OP_II; end
                    OP_II: begin r_ii <= mac_acc; r_op <= OP_P1; end
                    OP_P1: r_op <= OP_P2;
                    OP_P2: begin r_p <= mac_acc; r_op <= OP_Q1; end
                    OP_Q1: r_op <= OP_Q2;
                    OP_Q2: begin r_q <= mac_acc; r_op <= OP_X; end
                    OP_X:  begin r_x <= mac_acc; r_op <= OP_RR; end
                    default: r_op <= OP_RR;
                endcase
            end

            if (r_state == S_CHECK) begin
                r_sq <= r_rr + r_ii;
            end

            // orbit trap skips the starting point
            if (r_state == S_TEST && r_n != '0 && orbit_v < r_orbit) begin
                r_orbit <= orbit_v;
            end

            if (r_state == S_UPDATE) begin
                r_zr   <= nzr[63:0];
                r_zi   <= nzi[63:0];
                r_dr   <= ndr[63:0];
                r_di   <= ndi[63:0];
                r_dsat <= r_dsat | ndr[64] | ndi[64];
                r_n    <= r_n + COUNT_BITS'(1);
            end

            // load the result when the output is free, else drop valid once taken
            if (r_state == S_FINISH && out_free) begin
                r_out_valid <= 1'b1;
                r_o_iter    <= n32[15:0];
                r_o_inside  <= (r_n >= r_max);
                r_o_radius  <= (sq_q > RAD_MAX) ? RAD_MAX[53:0] : sq_q[53:0];
                r_o_orbit   <= r_orbit;
                r_o_dr      <= r_dr;
                r_o_di      <= r_di;
                r_o_dsat    <= r_dsat;
            end else if (i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {1'b0, r_o_di, r_o_dr, r_o_orbit, r_o_radius, r_o_iter};
    assign o_m_axis_tuser  = {r_o_dsat, r_o_inside};

    // an accepted item blocks the input until its result is out
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> !o_s_axis_tready)
        else $error("input ready right after an accepted item");

    // products only complete while the sequencer waits for them
    a_done_in_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mac_done |-> (r_state == S_WAIT))
        else $error("product finished outside the wait state");

    // orbit trap never exceeds its cap
    a_orbit_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_orbit <= ONE_Q32)
        else $error("orbit trap above 1.0");

    // result loads only with the output register free
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FINISH && r_out_valid && !i_m_axis_tready) |=>
            (r_state == S_FINISH))
        else $error("left finish while the output was still held");

endmodule
